### rtl/tlpq_pkg.sv
// Shared types, constants and helpers for the touch tap / long press qualifier.
package tlpq_pkg;

    localparam int TIME_BITS  = 16;
    localparam int COORD_BITS = 12;
    localparam int MAX_POINTS = 5;

    localparam int RAW_BITS   = 12;
    localparam int DIM_BITS   = 13;
    localparam int COUNT_BITS = 8;
    localparam int MIN_BITS   = 10;
    localparam int ROT_BITS   = 2;
    localparam int CALC_BITS  = DIM_BITS + 2;
    localparam int EV_BITS    = 3;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam int IN_BITS  = 2 + COUNT_BITS + 2 * RAW_BITS + 1;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = EV_BITS + 2 * COORD_BITS + 1 + TIME_BITS + 1;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef logic [TIME_BITS-1:0]  t_time;
    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [RAW_BITS-1:0]   t_raw;
    typedef logic [DIM_BITS-1:0]   t_dim;
    typedef logic [ROT_BITS-1:0]   t_rot;
    typedef logic signed [CALC_BITS-1:0] t_calc;

    localparam t_time TIME_MAX = {TIME_BITS{1'b1}};
    localparam t_calc COORD_MAX_S = t_calc'((2 ** COORD_BITS) - 1);

    localparam t_rot  RST_ROTATION  = t_rot'(0);
    localparam t_dim  RST_WIDTH     = t_dim'(172);
    localparam t_dim  RST_HEIGHT    = t_dim'(320);
    localparam t_time RST_DEBOUNCE  = t_time'(50);
    localparam t_time RST_LONG      = t_time'(1000);
    localparam t_time RST_TAP_BLOCK = t_time'(500);
    localparam logic [MIN_BITS-1:0] RST_MIN_TAP = MIN_BITS'(10);

    typedef enum logic [EV_BITS-1:0] {
        EV_NONE         = 3'd0,
        EV_PRESS        = 3'd1,
        EV_SHORT_TAP    = 3'd2,
        EV_LONG_RELEASE = 3'd3,
        EV_TAP_BLOCKED  = 3'd4,
        EV_TOO_SHORT    = 3'd5,
        EV_LONG_PRESS   = 3'd6
    } t_event;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ROTATION  = 3'd0,
        CFG_WIDTH     = 3'd1,
        CFG_HEIGHT    = 3'd2,
        CFG_DEBOUNCE  = 3'd3,
        CFG_LONG      = 3'd4,
        CFG_TAP_BLOCK = 3'd5,
        CFG_MIN_TAP   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic                     valid;
        logic [CFG_IDX_BITS-1:0]  index;
        logic [CFG_DATA_BITS-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic                  timer_start;
        t_raw                  raw_y;
        t_raw                  raw_x;
        logic [COUNT_BITS-1:0] report_count;
        logic                  report_ok;
        logic                  int_low;
    } t_item;

    typedef struct packed {
        logic   touched;
        t_time  duration_ms;
        logic   pos_valid;
        t_coord pos_y;
        t_coord pos_x;
        t_event event_res;
    } t_result;

    function automatic t_time sat_inc(input t_time v);
        sat_inc = (v == TIME_MAX) ? v : v + t_time'(1);
    endfunction

endpackage

### rtl/tlpq_rotate.sv
// Coordinate transform into display space with clamping at both ends.
module tlpq_rotate (
    input  tlpq_pkg::t_rot   i_rotation,
    input  tlpq_pkg::t_dim   i_width,
    input  tlpq_pkg::t_dim   i_height,
    input  tlpq_pkg::t_raw   i_raw_x,
    input  tlpq_pkg::t_raw   i_raw_y,
    output tlpq_pkg::t_coord o_x,
    output tlpq_pkg::t_coord o_y
);
    import tlpq_pkg::*;

    t_calc x_s, y_s, w_s, h_s, nx, ny;

    function automatic t_coord clamp(input t_calc v);
        if (v < 0) begin
            clamp = '0;
        end else if (v > COORD_MAX_S) begin
            clamp = {COORD_BITS{1'b1}};
        end else begin
            clamp = v[COORD_BITS-1:0];
        end
    endfunction

    always_comb begin
        x_s = t_calc'({1'b0, i_raw_x});
        y_s = t_calc'({1'b0, i_raw_y});
        w_s = t_calc'({1'b0, i_width});
        h_s = t_calc'({1'b0, i_height});
        case (i_rotation)
            2'd0: begin
                nx = w_s - t_calc'(1) - x_s;
                ny = y_s;
            end
            2'd1: begin
                nx = y_s;
                ny = x_s;
            end
            2'd2: begin
                nx = x_s;
                ny = h_s - t_calc'(1) - y_s;
            end
            default: begin
                nx = w_s - t_calc'(1) - y_s;
                ny = h_s - t_calc'(1) - x_s;
            end
        endcase
        o_x = clamp(nx);
        o_y = clamp(ny);
    end

endmodule

### rtl/tlpq_core.sv
// Configuration registers, touch state and per-tick event decision.
module tlpq_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tlpq_pkg::t_cfg_wr i_cfg,
    input  logic              i_adv,
    input  tlpq_pkg::t_item   i_item,
    output tlpq_pkg::t_result o_res
);
    import tlpq_pkg::*;

    t_rot                r_rotation;
    t_dim                r_width, r_height;
    t_time               r_debounce, r_long, r_tap_block;
    logic [MIN_BITS-1:0] r_min_tap;

    logic   r_prev_low, n_prev_low;
    logic   r_pt_live, n_pt_live;
    t_coord r_pt_x, n_pt_x, r_pt_y, n_pt_y;
    t_coord r_lat_x, n_lat_x, r_lat_y, n_lat_y;
    logic   r_lat_valid, n_lat_valid;
    t_time  r_since_low, n_since_low;
    t_time  r_since_ts, n_since_ts;
    logic   r_pressed, n_pressed;
    t_time  r_age, n_age;
    logic   r_long_done, n_long_done;

    t_coord rot_x, rot_y;
    t_time  age_inc, dur;
    t_event ev;
    logic   touched, count_good, blocked;

    tlpq_rotate u_rotate (
        .i_rotation (r_rotation),
        .i_width    (r_width),
        .i_height   (r_height),
        .i_raw_x    (i_item.raw_x),
        .i_raw_y    (i_item.raw_y),
        .o_x        (rot_x),
        .o_y        (rot_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation  <= RST_ROTATION;
            r_width     <= RST_WIDTH;
            r_height    <= RST_HEIGHT;
            r_debounce  <= RST_DEBOUNCE;
            r_long      <= RST_LONG;
            r_tap_block <= RST_TAP_BLOCK;
            r_min_tap   <= RST_MIN_TAP;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_ROTATION:  r_rotation  <= i_cfg.data[ROT_BITS-1:0];
                CFG_WIDTH:     r_width     <= i_cfg.data[DIM_BITS-1:0];
                CFG_HEIGHT:    r_height    <= i_cfg.data[DIM_BITS-1:0];
                CFG_DEBOUNCE:  r_debounce  <= i_cfg.data[TIME_BITS-1:0];
                CFG_LONG:      r_long      <= i_cfg.data[TIME_BITS-1:0];
                CFG_TAP_BLOCK: r_tap_block <= i_cfg.data[TIME_BITS-1:0];
                CFG_MIN_TAP:   r_min_tap   <= i_cfg.data[MIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        count_good = (i_item.report_count >= COUNT_BITS'(1))
                  && (i_item.report_count <= COUNT_BITS'(MAX_POINTS));

        n_since_low = i_item.int_low ? '0 : sat_inc(r_since_low);
        n_since_ts  = i_item.timer_start ? '0 : sat_inc(r_since_ts);
        age_inc     = r_pressed ? sat_inc(r_age) : r_age;

        n_pt_live = r_pt_live;
        n_pt_x    = r_pt_x;
        n_pt_y    = r_pt_y;
        if (i_item.int_low) begin
            if (i_item.report_ok) begin
                if (count_good) begin
                    n_pt_live = 1'b1;
                    n_pt_x    = rot_x;
                    n_pt_y    = rot_y;
                end else if (!r_prev_low) begin
                    n_pt_live = 1'b0;
                end
            end
        end else if (!r_prev_low) begin
            n_pt_live = 1'b0;
        end
        n_prev_low = i_item.int_low;

        touched = i_item.int_low || (n_since_low < r_debounce);

        n_lat_x     = r_lat_x;
        n_lat_y     = r_lat_y;
        n_lat_valid = r_lat_valid;
        if (n_pt_live) begin
            n_lat_x     = n_pt_x;
            n_lat_y     = n_pt_y;
            n_lat_valid = 1'b1;
        end

        blocked     = n_since_ts < r_tap_block;
        ev          = EV_NONE;
        dur         = '0;
        n_pressed   = r_pressed;
        n_age       = age_inc;
        n_long_done = r_long_done;
        if (touched && !r_pressed) begin
            n_pressed   = 1'b1;
            n_age       = '0;
            n_long_done = 1'b0;
            ev          = EV_PRESS;
        end else if (!touched && r_pressed) begin
            dur = age_inc;
            if (!r_long_done && (age_inc > t_time'(r_min_tap)) && !blocked) begin
                ev = EV_SHORT_TAP;
            end else if (r_long_done) begin
                ev = EV_LONG_RELEASE;
            end else if (blocked) begin
                ev = EV_TAP_BLOCKED;
            end else begin
                ev = EV_TOO_SHORT;
            end
            n_pressed   = 1'b0;
            n_long_done = 1'b0;
        end else if (r_pressed) begin
            if ((age_inc > r_long) && !r_long_done) begin
                n_long_done = 1'b1;
                ev          = EV_LONG_PRESS;
                dur         = age_inc;
            end
        end

        o_res.event_res   = ev;
        o_res.pos_x       = n_lat_x;
        o_res.pos_y       = n_lat_y;
        o_res.pos_valid   = n_lat_valid;
        o_res.duration_ms = dur;
        o_res.touched     = touched;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_low  <= 1'b0;
            r_pt_live   <= 1'b0;
            r_pt_x      <= '0;
            r_pt_y      <= '0;
            r_lat_x     <= '0;
            r_lat_y     <= '0;
            r_lat_valid <= 1'b0;
            r_since_low <= TIME_MAX;
            r_since_ts  <= TIME_MAX;
            r_pressed   <= 1'b0;
            r_age       <= '0;
            r_long_done <= 1'b0;
        end else if (i_adv) begin
            r_prev_low  <= n_prev_low;
            r_pt_live   <= n_pt_live;
            r_pt_x      <= n_pt_x;
            r_pt_y      <= n_pt_y;
            r_lat_x     <= n_lat_x;
            r_lat_y     <= n_lat_y;
            r_lat_valid <= n_lat_valid;
            r_since_low <= n_since_low;
            r_since_ts  <= n_since_ts;
            r_pressed   <= n_pressed;
            r_age       <= n_age;
            r_long_done <= n_long_done;
        end
    end

endmodule

### rtl/touch_tap_long_press_qualifier_unit.sv
// Top level of the touch tap / long press qualifier: stream ports and pipeline registers.
//
// One input word per millisecond tick arrives on the s_axis channel; it carries
// the interrupt level, the report status, the first point of the report and a
// timer start pulse. Every input word yields exactly one result word on the
// m_axis channel: the event code, the latched rotated position, its valid flag,
// the press duration and the debounced touch level.
// Configuration registers are written over the cfg channel (index, data); it is
// always ready and is meant to be used while no word is in flight.
// Pipeline: a word accepted on s_axis sits in the input register, is evaluated
// and lands in the result register, from which its result is offered on m_axis.
// Throughput: one word per cycle while m_axis takes results; the whole tick update is
// one pass of logic between the input register and the result register.
// Stall: while the result register holds an untaken word, the input register
// may still hand over if the result is taken in the same cycle; otherwise both
// hold and s_axis_tready drops once the input register is full.
// Reset (synchronous, active low): clears the valid flags of both registers, restores
// register defaults and the tick state (time-since counters saturated, no press, no position).
module touch_tap_long_press_qualifier_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // int_low, report_ok, report_count[7:0], raw_x[11:0], raw_y[11:0], timer_start, zero pad
    input  logic [tlpq_pkg::IN_W-1:0]             s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // event_res[2:0], pos_x[11:0], pos_y[11:0], pos_valid, duration_ms[15:0], touched, zero pad
    output logic [tlpq_pkg::OUT_W-1:0]            m_axis_tdata,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [tlpq_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [tlpq_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import tlpq_pkg::*;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out_res;
    t_result res;
    t_cfg_wr cfg_wr;
    logic    adv;

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign o_cfg_ready   = 1'b1;

    assign cfg_wr.valid = i_cfg_valid;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    tlpq_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_wr),
        .i_adv   (adv),
        .i_item  (r_in_item),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item <= s_axis_tdata[IN_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_res <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out_res);

endmodule
